@@ design/twc_pkg.sv @@
// ----------------------------------------------------------------------------
// twc_pkg
// Shared widths, codes and controller/datapath types of the text window console
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int KIND_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 40;

  localparam logic [COL_W-1:0]  WIN_LEFT_RST     = 7'd0;
  localparam logic [ROW_W-1:0]  WIN_TOP_RST      = 6'd0;
  localparam logic [COL_W-1:0]  WIN_COLS_RST     = 7'd80;
  localparam logic [ROW_W-1:0]  WIN_ROWS_RST     = 6'd40;
  localparam logic [CHAR_W-1:0] CURSOR_GLYPH_RST = 8'd32;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRINT = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_MOVE  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_LEFT     = 3'd0,
    CFG_WIN_TOP      = 3'd1,
    CFG_WIN_COLS     = 3'd2,
    CFG_WIN_ROWS     = 3'd3,
    CFG_CURSOR_GLYPH = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_SAT,
    CUR_PRINT,
    CUR_HOME,
    CUR_MOVE
  } cur_op_t;

  typedef enum logic [1:0] {
    LOOP_HOLD,
    LOOP_ZERO,
    LOOP_STEP
  } loop_op_t;

  typedef enum logic [2:0] {
    AS_CURSOR,
    AS_LOOP,
    AS_LOOP_BELOW,
    AS_LOOP_BOTTOM,
    AS_REQ
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_BLANK,
    WD_PRINT,
    WD_GLYPH,
    WD_RDATA
  } wdata_sel_t;

  typedef struct packed {
    logic       load_req;
    cur_op_t    cur_op;
    loop_op_t   loop_op;
    logic       mem_we;
    logic       mem_re;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
    logic       cell_load;
    logic       err_set;
    logic       out_load;
  } twc_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  scroll;
    logic  rows_one;
    logic  move_ok;
    logic  read_ok;
    logic  col_end;
    logic  row_last;
    logic  row_copy_last;
    logic  out_free;
  } twc_sts_t;

endpackage

@@ design/twc_ifs.sv @@
// ----------------------------------------------------------------------------
// twc_ifs
// Request, result and configuration channels of the text window console
// ----------------------------------------------------------------------------
interface twc_in_if;
  logic                         valid;
  logic                         ready;
  logic [twc_pkg::KIND_W-1:0]   kind;
  logic [twc_pkg::CHAR_W-1:0]   char_code;
  logic [twc_pkg::COL_W-1:0]    col;
  logic [twc_pkg::ROW_W-1:0]    row;

  modport source (output valid, kind, char_code, col, row, input ready);
  modport sink   (input valid, kind, char_code, col, row, output ready);
endinterface

interface twc_out_if;
  logic                         valid;
  logic                         ready;
  logic [twc_pkg::CHAR_W-1:0]   cell_char;
  logic [twc_pkg::COL_W-1:0]    cursor_col_out;
  logic [twc_pkg::ROW_W-1:0]    cursor_row_out;
  logic                         error;

  modport source (output valid, cell_char, cursor_col_out, cursor_row_out, error,
                  input ready);
  modport sink   (input valid, cell_char, cursor_col_out, cursor_row_out, error,
                  output ready);
endinterface

interface twc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [twc_pkg::CFG_IDX_W-1:0]    index;
  logic [twc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/twc_ram.sv @@
// ----------------------------------------------------------------------------
// twc_ram
// Generic single-port RAM with registered read data
// ----------------------------------------------------------------------------
module twc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 3200,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/twc_datapath.sv @@
// ----------------------------------------------------------------------------
// twc_datapath
// Window registers, cursor, sweep counters, screen store and result register
// ----------------------------------------------------------------------------
module twc_datapath #(
  parameter int SCREEN_COLS = twc_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = twc_pkg::SCREEN_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  twc_pkg::twc_cmd_t                cmd,
  output twc_pkg::twc_sts_t                sts,
  input  logic                             cfg_valid,
  input  logic [twc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [twc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [twc_pkg::KIND_W-1:0]       in_kind,
  input  logic [twc_pkg::CHAR_W-1:0]       in_char_code,
  input  logic [twc_pkg::COL_W-1:0]        in_col,
  input  logic [twc_pkg::ROW_W-1:0]        in_row,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [twc_pkg::CHAR_W-1:0]       out_cell_char,
  output logic [twc_pkg::COL_W-1:0]        out_cursor_col,
  output logic [twc_pkg::ROW_W-1:0]        out_cursor_row,
  output logic                             out_error
);

  localparam int CW     = twc_pkg::COL_W;
  localparam int RW     = twc_pkg::ROW_W;
  localparam int DEPTH  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [CW-1:0]                 win_left_r;
  logic [RW-1:0]                 win_top_r;
  logic [CW-1:0]                 win_cols_r;
  logic [RW-1:0]                 win_rows_r;
  logic [twc_pkg::CHAR_W-1:0]    glyph_r;

  // request and work state
  twc_pkg::kind_t                kind_r;
  logic [twc_pkg::CHAR_W-1:0]    ch_r;
  logic [CW-1:0]                 req_col_r;
  logic [RW-1:0]                 req_row_r;
  logic [CW-1:0]                 cur_col_r, cur_col_nxt;
  logic [RW-1:0]                 cur_row_r, cur_row_nxt;
  logic [CW-1:0]                 lc_r, lc_nxt;
  logic [RW-1:0]                 lr_r, lr_nxt;
  logic [twc_pkg::CHAR_W-1:0]    cell_r;
  logic                          err_r;

  // result register
  logic                          out_valid_r;
  logic [twc_pkg::CHAR_W-1:0]    out_cell_r;
  logic [CW-1:0]                 out_col_r;
  logic [RW-1:0]                 out_row_r;
  logic                          out_err_r;

  // effective window
  logic [CW-1:0]                 eff_left;
  logic [RW-1:0]                 eff_top;
  logic [CW:0]                   eff_cols, room_cols, lim_cols;
  logic [RW:0]                   eff_rows, room_rows, lim_rows;

  logic [CW:0]                   pc_w;
  logic [RW:0]                   pr_w;
  logic                          ch_special;

  logic [CW-1:0]                 a_col;
  logic [RW-1:0]                 a_row;
  logic [CW-1:0]                 scr_col;
  logic [RW-1:0]                 scr_row;
  logic [ADDR_W-1:0]             mem_addr;
  logic [twc_pkg::CHAR_W-1:0]    mem_wdata, mem_rdata;

  always_comb begin
    eff_left  = ({1'b0, win_left_r} < (CW+1)'(SCREEN_COLS)) ? win_left_r
                                                            : CW'(SCREEN_COLS - 1);
    room_cols = (CW+1)'(SCREEN_COLS) - {1'b0, eff_left};
    lim_cols  = ({1'b0, win_cols_r} > room_cols) ? room_cols : {1'b0, win_cols_r};
    eff_cols  = (lim_cols == '0) ? (CW+1)'(1) : lim_cols;

    eff_top   = ({1'b0, win_top_r} < (RW+1)'(SCREEN_ROWS)) ? win_top_r
                                                           : RW'(SCREEN_ROWS - 1);
    room_rows = (RW+1)'(SCREEN_ROWS) - {1'b0, eff_top};
    lim_rows  = ({1'b0, win_rows_r} > room_rows) ? room_rows : {1'b0, win_rows_r};
    eff_rows  = (lim_rows == '0) ? (RW+1)'(1) : lim_rows;
  end

  // cursor motion of a printed character
  always_comb begin
    ch_special = (ch_r == twc_pkg::CH_LF) || (ch_r == twc_pkg::CH_CR) ||
                 (ch_r == twc_pkg::CH_BS);
    pc_w = {1'b0, cur_col_r};
    pr_w = {1'b0, cur_row_r};
    if (ch_r == twc_pkg::CH_LF || ch_r == twc_pkg::CH_CR) begin
      pc_w = '0;
      pr_w = {1'b0, cur_row_r} + (RW+1)'(1);
    end else if (ch_r == twc_pkg::CH_BS) begin
      if (cur_col_r != '0) begin
        pc_w = {1'b0, cur_col_r} - (CW+1)'(1);
      end else if (cur_row_r != '0) begin
        pc_w = eff_cols - (CW+1)'(1);
        pr_w = {1'b0, cur_row_r} - (RW+1)'(1);
      end
    end else begin
      pc_w = {1'b0, cur_col_r} + (CW+1)'(1);
      if (pc_w == eff_cols) begin
        pc_w = '0;
        pr_w = {1'b0, cur_row_r} + (RW+1)'(1);
      end
    end
  end

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    case (cmd.cur_op)
      twc_pkg::CUR_SAT: begin
        if ({1'b0, cur_col_r} >= eff_cols) cur_col_nxt = CW'(eff_cols - (CW+1)'(1));
        if ({1'b0, cur_row_r} >= eff_rows) cur_row_nxt = RW'(eff_rows - (RW+1)'(1));
      end
      twc_pkg::CUR_PRINT: begin
        if (pr_w == eff_rows) begin
          cur_col_nxt = '0;
          cur_row_nxt = RW'(eff_rows - (RW+1)'(1));
        end else begin
          cur_col_nxt = CW'(pc_w);
          cur_row_nxt = RW'(pr_w);
        end
      end
      twc_pkg::CUR_HOME: begin
        cur_col_nxt = '0;
        cur_row_nxt = '0;
      end
      twc_pkg::CUR_MOVE: begin
        cur_col_nxt = req_col_r;
        cur_row_nxt = req_row_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    lc_nxt = lc_r;
    lr_nxt = lr_r;
    case (cmd.loop_op)
      twc_pkg::LOOP_ZERO: begin
        lc_nxt = '0;
        lr_nxt = '0;
      end
      twc_pkg::LOOP_STEP: begin
        if (sts.col_end) begin
          lc_nxt = '0;
          lr_nxt = lr_r + RW'(1);
        end else begin
          lc_nxt = lc_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // window-relative cell, or the requested screen cell for a read, to screen address
  always_comb begin
    a_col = cur_col_r;
    a_row = cur_row_r;
    unique case (cmd.addr_sel)
      twc_pkg::AS_CURSOR: begin
        a_col = cur_col_r;
        a_row = cur_row_r;
      end
      twc_pkg::AS_LOOP: begin
        a_col = lc_r;
        a_row = lr_r;
      end
      twc_pkg::AS_LOOP_BELOW: begin
        a_col = lc_r;
        a_row = lr_r + RW'(1);
      end
      twc_pkg::AS_LOOP_BOTTOM: begin
        a_col = lc_r;
        a_row = RW'(eff_rows - (RW+1)'(1));
      end
      default: ;
    endcase
    if (cmd.addr_sel == twc_pkg::AS_REQ) begin
      scr_col = req_col_r;
      scr_row = req_row_r;
    end else begin
      scr_col = eff_left + a_col;
      scr_row = eff_top + a_row;
    end
    mem_addr = ADDR_W'(scr_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(scr_col);
  end

  always_comb begin
    unique case (cmd.wdata_sel)
      twc_pkg::WD_BLANK: mem_wdata = twc_pkg::CH_BLANK;
      twc_pkg::WD_PRINT: mem_wdata = ch_special ? twc_pkg::CH_BLANK : ch_r;
      twc_pkg::WD_GLYPH: mem_wdata = glyph_r;
      twc_pkg::WD_RDATA: mem_wdata = mem_rdata;
      default:           mem_wdata = twc_pkg::CH_BLANK;
    endcase
  end

  twc_ram #(
    .WIDTH  (twc_pkg::CHAR_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_screen (
    .clk   (clk),
    .we    (cmd.mem_we),
    .re    (cmd.mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    sts.kind          = kind_r;
    sts.scroll        = (pr_w == eff_rows);
    sts.rows_one      = (eff_rows == (RW+1)'(1));
    sts.move_ok       = ({1'b0, req_col_r} < eff_cols) && ({1'b0, req_row_r} < eff_rows);
    sts.read_ok       = ({1'b0, req_col_r} < (CW+1)'(SCREEN_COLS)) &&
                        ({1'b0, req_row_r} < (RW+1)'(SCREEN_ROWS));
    sts.col_end       = ({1'b0, lc_r} + (CW+1)'(1) == eff_cols);
    sts.row_last      = ({1'b0, lr_r} + (RW+1)'(1) == eff_rows);
    sts.row_copy_last = ({1'b0, lr_r} + (RW+1)'(2) == eff_rows);
    sts.out_free      = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r  <= twc_pkg::WIN_LEFT_RST;
      win_top_r   <= twc_pkg::WIN_TOP_RST;
      win_cols_r  <= twc_pkg::WIN_COLS_RST;
      win_rows_r  <= twc_pkg::WIN_ROWS_RST;
      glyph_r     <= twc_pkg::CURSOR_GLYPH_RST;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          twc_pkg::CFG_WIN_LEFT:     win_left_r <= CW'(cfg_data);
          twc_pkg::CFG_WIN_TOP:      win_top_r  <= RW'(cfg_data);
          twc_pkg::CFG_WIN_COLS:     win_cols_r <= CW'(cfg_data);
          twc_pkg::CFG_WIN_ROWS:     win_rows_r <= RW'(cfg_data);
          twc_pkg::CFG_CURSOR_GLYPH: glyph_r    <= cfg_data;
          default: ;
        endcase
      end
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lc_r <= lc_nxt;
    lr_r <= lr_nxt;
    if (cmd.load_req) begin
      kind_r    <= twc_pkg::kind_t'(in_kind);
      ch_r      <= in_char_code;
      req_col_r <= in_col;
      req_row_r <= in_row;
      cell_r    <= '0;
      err_r     <= 1'b0;
    end else begin
      if (cmd.cell_load) cell_r <= mem_rdata;
      if (cmd.err_set)   err_r  <= 1'b1;
    end
    if (cmd.out_load) begin
      out_cell_r <= cell_r;
      out_col_r  <= cur_col_r;
      out_row_r  <= cur_row_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_cell_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_error      = out_err_r;

  a_wr_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_we |-> ({1'b0, mem_addr} < (ADDR_W+1)'(DEPTH)))
    else $error("screen write outside the store");

  a_cursor_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (({1'b0, cur_col_r} < eff_cols) && ({1'b0, cur_row_r} < eff_rows)))
    else $error("cursor outside the window at result");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && err_r) |-> (kind_r == twc_pkg::KIND_MOVE ||
                                 kind_r == twc_pkg::KIND_READ))
    else $error("error flag on a print or clear request");

endmodule

@@ design/twc_ctrl.sv @@
// ----------------------------------------------------------------------------
// twc_ctrl
// Request sequencer: dispatch, clear and scroll sweeps, glyph redraw, result
// ----------------------------------------------------------------------------
module twc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  twc_pkg::twc_sts_t sts,
  output twc_pkg::twc_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CLR,
    S_SCR_RD,
    S_SCR_WR,
    S_BLANK,
    S_GLYPH,
    S_RDWAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd           = '0;
    cmd.cur_op    = twc_pkg::CUR_HOLD;
    cmd.loop_op   = twc_pkg::LOOP_HOLD;
    cmd.addr_sel  = twc_pkg::AS_CURSOR;
    cmd.wdata_sel = twc_pkg::WD_BLANK;
    in_ready      = 1'b0;
    state_nxt     = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cmd.cur_op   = twc_pkg::CUR_SAT;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.kind)
          twc_pkg::KIND_PRINT: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = twc_pkg::AS_CURSOR;
            cmd.wdata_sel = twc_pkg::WD_PRINT;
            cmd.cur_op    = twc_pkg::CUR_PRINT;
            cmd.loop_op   = twc_pkg::LOOP_ZERO;
            if (!sts.scroll) begin
              state_nxt = S_GLYPH;
            end else if (sts.rows_one) begin
              state_nxt = S_BLANK;
            end else begin
              state_nxt = S_SCR_RD;
            end
          end
          twc_pkg::KIND_CLEAR: begin
            cmd.cur_op  = twc_pkg::CUR_HOME;
            cmd.loop_op = twc_pkg::LOOP_ZERO;
            state_nxt   = S_CLR;
          end
          twc_pkg::KIND_MOVE: begin
            if (sts.move_ok) begin
              cmd.cur_op = twc_pkg::CUR_MOVE;
            end else begin
              cmd.err_set = 1'b1;
            end
            state_nxt = S_DONE;
          end
          twc_pkg::KIND_READ: begin
            if (sts.read_ok) begin
              cmd.mem_re   = 1'b1;
              cmd.addr_sel = twc_pkg::AS_REQ;
              state_nxt    = S_RDWAIT;
            end else begin
              cmd.err_set = 1'b1;
              state_nxt   = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_CLR: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = twc_pkg::AS_LOOP;
        cmd.wdata_sel = twc_pkg::WD_BLANK;
        cmd.loop_op   = twc_pkg::LOOP_STEP;
        if (sts.col_end && sts.row_last) state_nxt = S_GLYPH;
      end
      S_SCR_RD: begin
        cmd.mem_re   = 1'b1;
        cmd.addr_sel = twc_pkg::AS_LOOP_BELOW;
        state_nxt    = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = twc_pkg::AS_LOOP;
        cmd.wdata_sel = twc_pkg::WD_RDATA;
        if (sts.col_end && sts.row_copy_last) begin
          cmd.loop_op = twc_pkg::LOOP_ZERO;
          state_nxt   = S_BLANK;
        end else begin
          cmd.loop_op = twc_pkg::LOOP_STEP;
          state_nxt   = S_SCR_RD;
        end
      end
      S_BLANK: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = twc_pkg::AS_LOOP_BOTTOM;
        cmd.wdata_sel = twc_pkg::WD_BLANK;
        cmd.loop_op   = twc_pkg::LOOP_STEP;
        if (sts.col_end) state_nxt = S_GLYPH;
      end
      S_GLYPH: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = twc_pkg::AS_CURSOR;
        cmd.wdata_sel = twc_pkg::WD_GLYPH;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDWAIT: begin
        cmd.cell_load = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted request not dispatched");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

endmodule

@@ design/text_window_console_core.sv @@
// ----------------------------------------------------------------------------
// text_window_console_core
// Character-cell text console with a windowed cursor over a screen store
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result. The screen store is a
// single-port RAM: a clear writes the window cells one by one, and a print
// that scrolls moves the window rows up, copying each cell with a read and
// a write, then blanks the bottom row. A finished result waits in the output
// register while the next request is accepted. The store holds whatever it
// held until written: issue a clear before reading cells. Configuration
// writes are always taken and must only be sent while no request is in
// flight.
module text_window_console_core #(
  parameter int SCREEN_COLS = twc_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = twc_pkg::SCREEN_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  twc_in_if.sink     in_chan,
  twc_out_if.source  out_chan,
  twc_cfg_if.sink    cfg_chan
);

  twc_pkg::twc_cmd_t cmd;
  twc_pkg::twc_sts_t sts;

  assign cfg_chan.ready = 1'b1;

  twc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  twc_datapath #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_chan.valid),
    .cfg_index      (cfg_chan.index),
    .cfg_data       (cfg_chan.data),
    .in_kind        (in_chan.kind),
    .in_char_code   (in_chan.char_code),
    .in_col         (in_chan.col),
    .in_row         (in_chan.row),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_cell_char  (out_chan.cell_char),
    .out_cursor_col (out_chan.cursor_col_out),
    .out_cursor_row (out_chan.cursor_row_out),
    .out_error      (out_chan.error)
  );

endmodule

@@ test/text_window_console_core_test.sv @@
// ----------------------------------------------------------------------------
// text_window_console_core_test
// Self-checking bench: a table of directed requests, then random requests
// over a series of window settings, each report checked against a table
// value or a cycle-free predictor kept in step with every accepted request
// ----------------------------------------------------------------------------
module text_window_console_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import twc_pkg::*;

  localparam int SCR_COLS = SCREEN_COLS_DEF;
  localparam int SCR_ROWS = SCREEN_ROWS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_REPORT = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_PHASES = 12;
  localparam int DIRECTED_ROWS = 22;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              error;
  } report_t;

  typedef struct packed {
    req_t    req;
    bit      typed;
    report_t want;
  } step_row_t;

  logic clk;
  logic rst_n;

  twc_in_if  req_ch ();
  twc_out_if rep_ch ();
  twc_cfg_if cfg_ch ();

  text_window_console_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (rep_ch),
    .cfg_chan (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #10ns;
    clk = 1'b1;
    #10ns;
  end

  // console mirror
  logic [CHAR_W-1:0] screen_mirror [SCR_COLS*SCR_ROWS];
  logic [COL_W-1:0]  win_left;
  logic [ROW_W-1:0]  win_top;
  logic [COL_W-1:0]  win_cols;
  logic [ROW_W-1:0]  win_rows;
  logic [CHAR_W-1:0] cursor_glyph;
  int eff_left, eff_top, eff_cols, eff_rows;
  int cur_col, cur_row;

  report_t report_q [$];
  bit steady;
  int fail_count;
  int reports_seen;
  int n_req, n_cfg, n_scrolls, n_flagged, n_clears;

  step_row_t directed_plan [DIRECTED_ROWS] = '{
    '{'{KIND_CLEAR, 8'd0, 7'd0, 6'd0}, 1'b1, '{8'd0, 7'd0, 6'd0, 1'b0}},
    '{'{KIND_READ, 8'd0, 7'd0, 6'd0}, 1'b1, '{8'd32, 7'd0, 6'd0, 1'b0}},
    '{'{KIND_READ, 8'd0, 7'd79, 6'd39}, 1'b1, '{8'd32, 7'd0, 6'd0, 1'b0}},
    '{'{KIND_READ, 8'd0, 7'd80, 6'd0}, 1'b1, '{8'd0, 7'd0, 6'd0, 1'b1}},
    '{'{KIND_READ, 8'd0, 7'd0, 6'd40}, 1'b1, '{8'd0, 7'd0, 6'd0, 1'b1}},
    '{'{KIND_READ, 8'hFF, 7'd127, 6'd63}, 1'b1, '{8'd0, 7'd0, 6'd0, 1'b1}},
    '{'{KIND_MOVE, 8'd0, 7'd79, 6'd39}, 1'b1, '{8'd0, 7'd79, 6'd39, 1'b0}},
    '{'{KIND_MOVE, 8'd0, 7'd80, 6'd39}, 1'b1, '{8'd0, 7'd79, 6'd39, 1'b1}},
    '{'{KIND_MOVE, 8'd0, 7'd79, 6'd40}, 1'b1, '{8'd0, 7'd79, 6'd39, 1'b1}},
    '{'{KIND_PRINT, 8'd65, 7'd0, 6'd0}, 1'b0, '0},
    '{'{KIND_READ, 8'd0, 7'd79, 6'd38}, 1'b0, '0},
    '{'{KIND_PRINT, CH_BS, 7'd0, 6'd0}, 1'b0, '0},
    '{'{KIND_MOVE, 8'd0, 7'd0, 6'd0}, 1'b1, '{8'd0, 7'd0, 6'd0, 1'b0}},
    '{'{KIND_PRINT, CH_BS, 7'd0, 6'd0}, 1'b1, '{8'd0, 7'd0, 6'd0, 1'b0}},
    '{'{KIND_PRINT, CH_LF, 7'd0, 6'd0}, 1'b0, '0},
    '{'{KIND_PRINT, CH_CR, 7'd0, 6'd0}, 1'b0, '0},
    '{'{KIND_PRINT, 8'd0, 7'd0, 6'd0}, 1'b0, '0},
    '{'{KIND_PRINT, 8'hFF, 7'd127, 6'd63}, 1'b0, '0},
    '{'{KIND_READ, 8'd0, 7'd0, 6'd2}, 1'b0, '0},
    '{'{KIND_READ, 8'd0, 7'd1, 6'd2}, 1'b0, '0},
    '{'{KIND_MOVE, 8'hFF, 7'd127, 6'd63}, 1'b0, '0},
    '{'{KIND_CLEAR, 8'hFF, 7'd127, 6'd63}, 1'b1, '{8'd0, 7'd0, 6'd0, 1'b0}}
  };

  function automatic void fix_window();
    eff_left = (win_left < SCR_COLS) ? int'(win_left) : SCR_COLS - 1;
    eff_top  = (win_top < SCR_ROWS) ? int'(win_top) : SCR_ROWS - 1;
    eff_cols = win_cols;
    if (eff_cols > SCR_COLS - eff_left) eff_cols = SCR_COLS - eff_left;
    if (eff_cols == 0) eff_cols = 1;
    eff_rows = win_rows;
    if (eff_rows > SCR_ROWS - eff_top) eff_rows = SCR_ROWS - eff_top;
    if (eff_rows == 0) eff_rows = 1;
  endfunction

  function automatic void put_cell(int c, int r, logic [CHAR_W-1:0] v);
    int sc, sr;
    sc = eff_left + c;
    sr = eff_top + r;
    if (sc < SCR_COLS && sr < SCR_ROWS) screen_mirror[sr*SCR_COLS + sc] = v;
  endfunction

  function automatic logic [CHAR_W-1:0] get_cell(int c, int r);
    int sc, sr;
    sc = eff_left + c;
    sr = eff_top + r;
    if (sc < SCR_COLS && sr < SCR_ROWS) return screen_mirror[sr*SCR_COLS + sc];
    return '0;
  endfunction

  function automatic void roll_window_up();
    for (int r = 0; r + 1 < eff_rows; r++)
      for (int c = 0; c < eff_cols; c++) put_cell(c, r, get_cell(c, r + 1));
    for (int c = 0; c < eff_cols; c++) put_cell(c, eff_rows - 1, CH_BLANK);
    cur_col = 0;
    cur_row = eff_rows - 1;
    n_scrolls++;
  endfunction

  function automatic void print_char(logic [CHAR_W-1:0] ch);
    put_cell(cur_col, cur_row, CH_BLANK);
    if (ch == CH_LF || ch == CH_CR) begin
      cur_col = 0;
      cur_row++;
    end else if (ch == CH_BS) begin
      if (cur_col != 0) begin
        cur_col--;
      end else if (cur_row != 0) begin
        cur_col = eff_cols - 1;
        cur_row--;
      end
    end else begin
      put_cell(cur_col, cur_row, ch);
      cur_col++;
      if (cur_col == eff_cols) begin
        cur_col = 0;
        cur_row++;
      end
    end
    if (cur_row == eff_rows) roll_window_up();
    put_cell(cur_col, cur_row, cursor_glyph);
  endfunction

  function automatic void blank_window();
    cur_col = 0;
    cur_row = 0;
    for (int r = 0; r < eff_rows; r++)
      for (int c = 0; c < eff_cols; c++) put_cell(c, r, CH_BLANK);
    put_cell(0, 0, cursor_glyph);
    n_clears++;
  endfunction

  function automatic report_t console_apply(req_t q);
    report_t o;
    o = '0;
    fix_window();
    if (cur_col >= eff_cols) cur_col = eff_cols - 1;
    if (cur_row >= eff_rows) cur_row = eff_rows - 1;
    case (q.kind)
      KIND_PRINT: print_char(q.char_code);
      KIND_CLEAR: blank_window();
      KIND_MOVE: begin
        if (q.col < eff_cols && q.row < eff_rows) begin
          cur_col = q.col;
          cur_row = q.row;
        end else begin
          o.error = 1'b1;
        end
      end
      default: begin
        if (q.col < SCR_COLS && q.row < SCR_ROWS)
          o.cell_char = screen_mirror[int'(q.row)*SCR_COLS + int'(q.col)];
        else
          o.error = 1'b1;
      end
    endcase
    if (o.error) n_flagged++;
    o.cursor_col = COL_W'(cur_col);
    o.cursor_row = ROW_W'(cur_row);
    return o;
  endfunction

  function automatic req_t random_request();
    req_t q;
    int pick;
    fix_window();
    q.char_code = CHAR_W'($urandom);
    q.col = COL_W'($urandom);
    q.row = ROW_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) begin
      q.kind = KIND_PRINT;
      pick = $urandom_range(99);
      if (pick < 10) q.char_code = CH_LF;
      else if (pick < 14) q.char_code = CH_CR;
      else if (pick < 24) q.char_code = CH_BS;
      else if (pick < 84) q.char_code = CHAR_W'($urandom_range(126, 33));
    end else if (pick < 78) begin
      q.kind = KIND_MOVE;
      if ($urandom_range(99) < 80) begin
        q.col = COL_W'($urandom_range(eff_cols - 1));
        q.row = ROW_W'($urandom_range(eff_rows - 1));
      end
    end else if (pick < 96) begin
      q.kind = KIND_READ;
      if ($urandom_range(99) < 85) begin
        q.col = COL_W'($urandom_range(eff_left + eff_cols - 1, eff_left));
        q.row = ROW_W'($urandom_range(eff_top + eff_rows - 1, eff_top));
      end
    end else begin
      q.kind = KIND_CLEAR;
    end
    return q;
  endfunction

  // entered and left at a falling edge, valid still high on return
  task automatic offer_request(input req_t q, input bit typed, input report_t fixed);
    report_t want;
    if (!steady) begin
      while ($urandom_range(99) < 32) begin
        req_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= q.kind;
    req_ch.char_code <= q.char_code;
    req_ch.col       <= q.col;
    req_ch.row       <= q.row;
    do @(posedge clk); while (!req_ch.ready);
    want = console_apply(q);
    if (typed) want = fixed;
    report_q.push_back(want);
    n_req++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_WIN_LEFT:     win_left = val[COL_W-1:0];
      CFG_WIN_TOP:      win_top = val[ROW_W-1:0];
      CFG_WIN_COLS:     win_cols = val[COL_W-1:0];
      CFG_WIN_ROWS:     win_rows = val[ROW_W-1:0];
      CFG_CURSOR_GLYPH: cursor_glyph = val;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic set_window(input logic [7:0] left, input logic [7:0] top,
                            input logic [7:0] cols, input logic [7:0] rows,
                            input logic [7:0] glyph, input bit spare);
    req_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    write_reg(CFG_WIN_LEFT, left);
    write_reg(CFG_WIN_TOP, top);
    write_reg(CFG_WIN_COLS, cols);
    write_reg(CFG_WIN_ROWS, rows);
    write_reg(CFG_CURSOR_GLYPH, glyph);
    if (spare) write_reg(CFG_SPARE_IDX, 8'hA5);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random back-pressure plus one long hold
  initial begin : report_drain
    bit hold_done;
    hold_done = 1'b0;
    rep_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && reports_seen >= HOLD_AT_REPORT) begin
        hold_done = 1'b1;
        rep_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rep_ch.ready <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (rst_n && rep_ch.valid && rep_ch.ready) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        $error("report with no request outstanding");
        fail_count++;
      end else begin
        want = report_q.pop_front();
        if (rep_ch.cell_char !== want.cell_char) begin
          $error("cell_char: expected %0d, got %0d", want.cell_char, rep_ch.cell_char);
          fail_count++;
        end
        if (rep_ch.cursor_col_out !== want.cursor_col) begin
          $error("cursor_col_out: expected %0d, got %0d", want.cursor_col,
                 rep_ch.cursor_col_out);
          fail_count++;
        end
        if (rep_ch.cursor_row_out !== want.cursor_row) begin
          $error("cursor_row_out: expected %0d, got %0d", want.cursor_row,
                 rep_ch.cursor_row_out);
          fail_count++;
        end
        if (rep_ch.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, rep_ch.error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if ((req_ch.valid && req_ch.ready) || (rep_ch.valid && rep_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int items;
    logic [7:0] left, top;
    steady = 1'b0;
    fail_count = 0;
    reports_seen = 0;
    n_req = 0;
    n_cfg = 0;
    n_scrolls = 0;
    n_flagged = 0;
    n_clears = 0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_PRINT;
    req_ch.char_code = '0;
    req_ch.col = '0;
    req_ch.row = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    win_left = WIN_LEFT_RST;
    win_top = WIN_TOP_RST;
    win_cols = WIN_COLS_RST;
    win_rows = WIN_ROWS_RST;
    cursor_glyph = CURSOR_GLYPH_RST;
    cur_col = 0;
    cur_row = 0;
    foreach (screen_mirror[i]) screen_mirror[i] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // full-screen clear first so every cell is written before any read
    for (int i = 0; i < DIRECTED_ROWS; i++)
      offer_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      items = 70;
      case (ph)
        0: set_window(8'd79, 8'd39, 8'd80, 8'd40, 8'd0, 1'b0);
        1: set_window(8'hFF, 8'hFF, 8'd0, 8'd0, 8'hFF, 1'b1);
        2: begin
          set_window(8'd0, 8'd0, 8'd127, 8'd63, 8'($urandom), 1'b0);
          items = 40;
        end
        3: begin
          left = 8'($urandom_range(79, 40));
          top = 8'($urandom_range(39, 20));
          set_window(left, top, 8'd127, 8'd63, 8'($urandom), 1'b0);
        end
        default: begin
          left = 8'($urandom_range(79));
          top = 8'($urandom_range(39));
          set_window(left, top, 8'($urandom_range(16, 1)), 8'($urandom_range(8, 1)),
                     8'($urandom), 1'b0);
        end
      endcase
      steady = (ph == 5);
      for (int i = 0; i < items; i++) offer_request(random_request(), 1'b0, '0);
      steady = 1'b0;
    end

    req_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d requests and %0d register writes over %0d window settings",
             n_req, n_cfg, NUM_PHASES + 1);
    $display("window scrolls %0d, clears %0d, flagged moves or reads %0d",
             n_scrolls, n_clears, n_flagged);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/twc_pkg.sv
design/twc_ifs.sv
design/twc_ram.sv
design/twc_datapath.sv
design/twc_ctrl.sv
design/text_window_console_core.sv
test/text_window_console_core_test.sv
